// ===== design/cmbi_pkg.sv =====
package cmbi_pkg;

	localparam int V_W      = 34;
	localparam int E_W      = 15;
	localparam int ACC_W    = 32;
	localparam int M_W      = 31;
	localparam int X_W      = 52;
	localparam int R_W      = 20;
	localparam int N_W      = 5;
	localparam int BL_W     = 6;
	localparam int EXP_LIM  = 14;
	localparam int BASE_W   = 17;
	localparam int ADDR_W   = 18;
	localparam int BL_STAGES = 5;
	localparam int IN_TD_W  = 96;
	localparam int OUT_TD_W = 40;
	localparam int CFG_D_W  = 9;
	localparam int FRAC_W   = 16;

	localparam logic [16:0] SPAN_U = 17'h10000;
	localparam logic [16:0] SPAN_S = 17'h0ffff;

	typedef enum logic [1:0] {
		TT_S16 = 2'd0,
		TT_U32 = 2'd1,
		TT_S32 = 2'd2
	} tt_e;

	typedef enum logic [0:0] {
		REG_TABLE_TYPE = 1'b0,
		REG_ROW_LENGTH = 1'b1
	} cfg_reg_e;

	typedef struct packed {
		logic              lookup;
		tt_e               kind;
		logic [FRAC_W-1:0] rf;
		logic [FRAC_W-1:0] cf;
	} side_t;

	function automatic tt_e tt_decode(input logic [1:0] r);
		tt_e k;
		if (r == TT_S16)
			k = TT_S16;
		else if (r == TT_U32)
			k = TT_U32;
		else
			k = TT_S32;
		return k;
	endfunction

	function automatic logic signed [V_W-1:0] fetch_entry(input logic [31:0] w, input tt_e k,
		input logic ok);
		logic signed [V_W-1:0] v;
		unique case (k)
			TT_S16:  v = V_W'($signed(w[15:0]));
			TT_U32:  v = $signed({2'b00, w});
			default: v = V_W'($signed(w));
		endcase
		if (!ok)
			v = '0;
		return v;
	endfunction

	function automatic logic [BL_W-1:0] bit_len(input logic [V_W-1:0] v);
		logic [BL_W-1:0] l;
		l = '0;
		for (int i = 0; i < V_W; i++)
			if (v[i])
				l = BL_W'(i + 1);
		return l;
	endfunction

endpackage

// ===== design/calibration_map_bilinear_interp.sv =====
// Calibration table with interpolated lookups. A beat with tuser low writes the low 32 bits
// of entry_value into the table; a beat with tuser high looks up (row_index, col_index) and
// blends the neighboring entries with the 16-bit fractions: bilinear for table types 0
// (signed 16-bit) and 1 (unsigned 32-bit), linear along the row axis for type 2 (and 3).
// Every beat gives one result beat, in order; write beats return zero with tuser low.
// One beat is taken every cycle unless output back-pressure has filled the pipeline. A beat
// passes an address register and the table read register, then two chained five-stage blend
// units. The table is held in two identical banks of two read ports each, so the four
// corner entries come out in the same cycle. A lookup sees every write accepted before it.
// Table contents are undefined after reset until written; there is no clearing pass.
// Configuration writes are taken at any time but must only be issued while the block is empty.
module calibration_map_bilinear_interp #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// entry_address[7:0], entry_value[40:8], row_index[48:41], row_frac[64:49],
	// col_index[72:65], col_frac[88:73], zero pad
	input  logic [cmbi_pkg::IN_TD_W-1:0]      s_axis_tdata,
	input  logic                              s_axis_tuser,   // command
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [cmbi_pkg::OUT_TD_W-1:0]     m_axis_tdata,   // value[32:0], zero pad
	output logic                              m_axis_tuser,   // was_lookup
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [cmbi_pkg::CFG_D_W-1:0]      cfg_data
);
	import cmbi_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int NS = 12;

	logic [1:0]         tt_q;
	logic [CFG_D_W-1:0] rl_q;

	logic [NS+1:1] en;
	logic          vld_s [1:NS];
	side_t         side_s [1:NS];

	logic [BASE_W-1:0] base_s1;
	logic [7:0]        wa_s1;
	logic [31:0]       wv_s1;

	logic [BASE_W-1:0] base_n;
	tt_e               kind_in;
	logic [ADDR_W-1:0] ad0, ad1, ad2, ad3, wad;
	logic [3:0]        rng;
	logic              wr_ok, mem_we;
	logic [3:0]        rng_s2;

	logic [31:0] w0, w1, w2, w3;
	logic signed [V_W-1:0] fa0, fa1, fa2, fa3;
	logic [FRAC_W-1:0]     fa_f;
	logic signed [V_W-1:0] res_a0, res_a1, res_b, out_v;
	logic signed [V_W-1:0] byp_s [8:NS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tt_q <= TT_S16;
			rl_q <= CFG_D_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_TABLE_TYPE: tt_q <= cfg_data[1:0];
				REG_ROW_LENGTH: rl_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		en[NS+1] = m_axis_tready;
		for (int k = NS; k >= 1; k--)
			en[k] = !vld_s[k] || en[k+1];
	end

	assign s_axis_tready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NS; k++)
				vld_s[k] <= 1'b0;
		end else begin
			if (en[1])
				vld_s[1] <= s_axis_tvalid;
			for (int k = 2; k <= NS; k++)
				if (en[k])
					vld_s[k] <= vld_s[k-1];
		end
	end

	// entry (r, c) sits at r * row_length + c; types 2 and 3 index by row only
	always_comb begin
		kind_in = tt_decode(tt_q);
		if (kind_in == TT_S32)
			base_n = BASE_W'(s_axis_tdata[48:41]);
		else
			base_n = BASE_W'(BASE_W'(s_axis_tdata[48:41]) * BASE_W'(rl_q))
				+ BASE_W'(s_axis_tdata[72:65]);
	end

	always_comb begin
		ad0    = ADDR_W'(base_s1);
		ad1    = ad0 + ADDR_W'(1);
		ad2    = ad0 + ADDR_W'(rl_q);
		ad3    = ad2 + ADDR_W'(1);
		rng[0] = ad0 < ADDR_W'(TABLE_DEPTH);
		rng[1] = ad1 < ADDR_W'(TABLE_DEPTH);
		rng[2] = ad2 < ADDR_W'(TABLE_DEPTH);
		rng[3] = ad3 < ADDR_W'(TABLE_DEPTH);
		wad    = ADDR_W'(wa_s1);
		wr_ok  = wad < ADDR_W'(TABLE_DEPTH);
		mem_we = vld_s[1] && !side_s[1].lookup && wr_ok && en[2];
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			side_s[1] <= '{lookup: s_axis_tuser, kind: kind_in,
				rf: s_axis_tdata[64:49], cf: s_axis_tdata[88:73]};
			base_s1   <= base_n;
			wa_s1     <= s_axis_tdata[7:0];
			wv_s1     <= s_axis_tdata[39:8];
		end
		if (en[2])
			rng_s2 <= rng;
		for (int k = 2; k <= NS; k++)
			if (en[k])
				side_s[k] <= side_s[k-1];
		if (en[8])
			byp_s[8] <= res_a0;
		for (int k = 9; k <= NS; k++)
			if (en[k])
				byp_s[k] <= byp_s[k-1];
	end

	cmbi_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_bank0 (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (wad[AW-1:0]),
		.wdata  (wv_s1),
		.re     (en[2]),
		.raddr0 (ad0[AW-1:0]),
		.raddr1 (ad1[AW-1:0]),
		.rdata0 (w0),
		.rdata1 (w1)
	);

	cmbi_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_bank1 (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (wad[AW-1:0]),
		.wdata  (wv_s1),
		.re     (en[2]),
		.raddr0 (ad2[AW-1:0]),
		.raddr1 (ad3[AW-1:0]),
		.rdata0 (w2),
		.rdata1 (w3)
	);

	always_comb begin
		fa0  = fetch_entry(w0, side_s[2].kind, rng_s2[0]);
		fa1  = fetch_entry(w1, side_s[2].kind, rng_s2[1]);
		fa2  = fetch_entry(w2, side_s[2].kind, rng_s2[2]);
		fa3  = fetch_entry(w3, side_s[2].kind, rng_s2[3]);
		fa_f = (side_s[2].kind == TT_S32) ? side_s[2].rf : side_s[2].cf;
	end

	cmbi_blend u_row0 (
		.clk  (clk),
		.en   (en[7:3]),
		.kind (side_s[2].kind),
		.a    (fa0),
		.b    (fa1),
		.f    (fa_f),
		.res  (res_a0)
	);

	cmbi_blend u_row1 (
		.clk  (clk),
		.en   (en[7:3]),
		.kind (side_s[2].kind),
		.a    (fa2),
		.b    (fa3),
		.f    (side_s[2].cf),
		.res  (res_a1)
	);

	cmbi_blend u_col (
		.clk  (clk),
		.en   (en[12:8]),
		.kind (side_s[7].kind),
		.a    (res_a0),
		.b    (res_a1),
		.f    (side_s[7].rf),
		.res  (res_b)
	);

	always_comb begin
		out_v         = (side_s[NS].kind == TT_S32) ? byp_s[NS] : res_b;
		m_axis_tvalid = vld_s[NS];
		m_axis_tuser  = side_s[NS].lookup;
		m_axis_tdata  = side_s[NS].lookup ? OUT_TD_W'(out_v[32:0]) : '0;
	end

	a_stall_from_output : assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> vld_s[NS] && !m_axis_tready)
		else $error("input stalled without output backpressure");

	a_read_stage_holds : assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[2] && !en[2] |=> vld_s[2] && $stable(side_s[2]) && $stable(rng_s2))
		else $error("read stage changed while stalled");

	a_bypass_load : assert property (@(posedge clk) disable iff (!arst_n)
		en[8] |=> byp_s[8] === $past(res_a0))
		else $error("linear bypass lost row blend");

endmodule

// ===== design/cmbi_table.sv =====
module cmbi_table #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [31:0]   rdata0,
	output logic [31:0]   rdata1
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

// ===== design/cmbi_blend.sv =====
module cmbi_blend (
	input  logic                                clk,
	input  logic [cmbi_pkg::BL_STAGES-1:0]      en,
	input  cmbi_pkg::tt_e                       kind,
	input  logic signed [cmbi_pkg::V_W-1:0]     a,
	input  logic signed [cmbi_pkg::V_W-1:0]     b,
	input  logic [cmbi_pkg::FRAC_W-1:0]         f,
	output logic signed [cmbi_pkg::V_W-1:0]     res
);
	import cmbi_pkg::*;

	logic [V_W-1:0]    ma, mb;
	logic [BL_W-1:0]   bl;
	logic [N_W-1:0]    n;

	logic [V_W-1:0]    ma_s1, mb_s1;
	logic              sa_s1, sb_s1;
	logic [N_W-1:0]    n_s1;
	logic [FRAC_W-1:0] f_s1;
	tt_e               k_s1;

	logic [V_W-1:0]        sha, shb;
	logic signed [E_W-1:0] ta, tb, ea, eb;

	logic signed [E_W-1:0] ea_s2, eb_s2;
	logic [N_W-1:0]        n_s2;
	logic [FRAC_W-1:0]     f_s2;
	tt_e                   k_s2;

	logic [16:0]             span;
	logic signed [ACC_W-1:0] ae, be, fw, ww, acc;
	logic                    neg;
	logic [M_W-1:0]          mag;

	logic [M_W-1:0] mag_s3;
	logic           neg_s3;
	logic [N_W-1:0] n_s3;
	tt_e            k_s3;

	logic [X_W-1:0] xw, x, q0;

	logic [X_W-1:0] x_s4, q0_s4;
	logic           neg_s4;
	logic [N_W-1:0] n_s4;
	tt_e            k_s4;

	logic [X_W-1:0] pm, q, qd, qs, qc;
	logic [R_W-1:0] r;
	logic [R_W:0]   rr;

	logic signed [V_W-1:0] res_s5;

	// stage 1: magnitudes and common halving count
	always_comb begin
		ma = a[V_W-1] ? V_W'(-a) : V_W'(a);
		mb = b[V_W-1] ? V_W'(-b) : V_W'(b);
		bl = bit_len(ma | mb);
		n  = (bl > BL_W'(EXP_LIM)) ? N_W'(bl - BL_W'(EXP_LIM)) : '0;
	end

	// stage 2: scaled endpoints, truncated toward zero
	always_comb begin
		sha = ma_s1 >> n_s1;
		shb = mb_s1 >> n_s1;
		ta  = E_W'(sha);
		tb  = E_W'(shb);
		ea  = sa_s1 ? -ta : ta;
		eb  = sb_s1 ? -tb : tb;
	end

	// stage 3: weighted sum
	always_comb begin
		span = (k_s2 == TT_U32) ? SPAN_U : SPAN_S;
		ae   = ACC_W'(ea_s2);
		be   = ACC_W'(eb_s2);
		fw   = ACC_W'(f_s2);
		ww   = ACC_W'(span - {1'b0, f_s2});
		acc  = be * fw + ae * ww;
		neg  = acc[ACC_W-1];
		mag  = M_W'(neg ? -acc : acc);
	end

	// stage 4: prescale and first quotient estimate for /0xffff
	always_comb begin
		xw = X_W'(mag_s3);
		x  = (k_s3 == TT_S16) ? (xw << n_s3) : xw;
		q0 = (x >> 16) + (x >> 32) + (x >> 48);
	end

	// stage 5: remainder correction, rescale, sign
	always_comb begin
		pm = (q0_s4 << 16) - q0_s4;
		r  = R_W'(x_s4 - pm);
		rr = {1'b0, r} + (R_W + 1)'(r >> 16) + (R_W + 1)'(1);
		qc = X_W'(rr >> 16);
		qd = q0_s4 + qc;
		q  = (k_s4 == TT_U32) ? (x_s4 >> 16) : qd;
		qs = (k_s4 == TT_S16) ? q : (q << n_s4);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ma_s1 <= ma;
			mb_s1 <= mb;
			sa_s1 <= a[V_W-1];
			sb_s1 <= b[V_W-1];
			n_s1  <= n;
			f_s1  <= f;
			k_s1  <= kind;
		end
		if (en[1]) begin
			ea_s2 <= ea;
			eb_s2 <= eb;
			n_s2  <= n_s1;
			f_s2  <= f_s1;
			k_s2  <= k_s1;
		end
		if (en[2]) begin
			mag_s3 <= mag;
			neg_s3 <= neg;
			n_s3   <= n_s2;
			k_s3   <= k_s2;
		end
		if (en[3]) begin
			x_s4   <= x;
			q0_s4  <= q0;
			neg_s4 <= neg_s3;
			n_s4   <= n_s3;
			k_s4   <= k_s3;
		end
		if (en[4])
			res_s5 <= V_W'(neg_s4 ? -qs : qs);
	end

	assign res = res_s5;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import cmbi_pkg::*;

	localparam int DEPTH = 256;
	localparam int LAT   = 12;

	typedef struct {
		logic        cmd;
		logic [7:0]  addr;
		logic [32:0] val;
		logic [7:0]  ri;
		logic [15:0] rf;
		logic [7:0]  ci;
		logic [15:0] cf;
	} op_t;

	typedef struct {
		logic [32:0] value;
		logic        was_lookup;
	} res_t;

	typedef struct {
		op_t   op;
		logic  typed;
		res_t  res;
	} row_t;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [IN_TD_W-1:0]  s_axis_tdata;
	logic                s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OUT_TD_W-1:0] m_axis_tdata;
	logic                m_axis_tuser;
	logic                cfg_valid;
	logic                cfg_ready;
	logic                cfg_index;
	logic [CFG_D_W-1:0]  cfg_data;

	logic [31:0] cal_table [DEPTH];
	bit          written [DEPTH];
	logic [1:0]  cur_type;
	logic [8:0]  cur_len;
	res_t        pending_results [$];
	int          mismatches;
	bit          quiet;

	calibration_map_bilinear_interp dut (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

	always @(negedge clk)
		m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 16);

	function automatic int halvings(longint v);
		int n;
		n = 0;
		while (v >= 16384 || v <= -16384) begin
			v = v / 2;
			n++;
		end
		return n;
	endfunction

	function automatic longint blend(longint a, longint b, longint f, longint span, bit sf);
		int     n;
		longint factor;
		longint acc;
		n = halvings(a);
		if (halvings(b) > n)
			n = halvings(b);
		factor = longint'(1) << n;
		a = a / factor;
		b = b / factor;
		acc = b * f + a * (span - f);
		if (sf)
			return (acc * factor) / span;
		return (acc / span) * factor;
	endfunction

	function automatic longint entry(longint unsigned addr, logic [1:0] kind);
		logic [31:0] w;
		if (addr >= DEPTH)
			return 0;
		w = cal_table[addr];
		if (kind == TT_S16)
			return longint'($signed(w[15:0]));
		if (kind == TT_U32)
			return longint'({32'b0, w});
		return longint'($signed(w));
	endfunction

	function automatic bit reads_unwritten(op_t op);
		longint unsigned r0, r1;
		longint unsigned a[4];
		if (cur_type == TT_S16 || cur_type == TT_U32) begin
			r0 = 32'(32'(op.ri) * 32'(cur_len) + 32'(op.ci));
			r1 = 32'(r0 + cur_len);
			a = '{r0, 32'(r0 + 1), r1, 32'(r1 + 1)};
		end else
			a = '{op.ri, op.ri + 1, op.ri, op.ri};
		foreach (a[i])
			if (a[i] < DEPTH && !written[a[i]])
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic res_t interpolate(op_t op);
		res_t   r;
		longint res, span, v0, v1;
		longint unsigned r0, r1;
		bit     sf;
		r.was_lookup = op.cmd;
		if (!op.cmd) begin
			cal_table[op.addr] = op.val[31:0];
			written[op.addr] = 1'b1;
			r.value = '0;
			return r;
		end
		if (cur_type == TT_S16 || cur_type == TT_U32) begin
			sf = (cur_type == TT_S16);
			span = sf ? 64'hffff : 64'h10000;
			r0 = 32'(32'(op.ri) * 32'(cur_len) + 32'(op.ci));
			r1 = 32'(r0 + cur_len);
			v0 = blend(entry(r0, cur_type), entry(32'(r0 + 1), cur_type), op.cf, span, sf);
			v1 = blend(entry(r1, cur_type), entry(32'(r1 + 1), cur_type), op.cf, span, sf);
			res = blend(v0, v1, op.rf, span, sf);
		end else
			res = blend(entry(op.ri, TT_S32), entry(op.ri + 1, TT_S32), op.rf, 64'hffff, 1'b0);
		r.value = res[32:0];
		return r;
	endfunction

	task automatic report(string what, logic [32:0] got, logic [32:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0)
				report("unexpected beat", m_axis_tdata[32:0], '0);
			else begin
				res_t e;
				e = pending_results.pop_front();
				if (m_axis_tdata[32:0] !== e.value)
					report("value", m_axis_tdata[32:0], e.value);
				if (m_axis_tuser !== e.was_lookup)
					report("was_lookup", 33'(m_axis_tuser), 33'(e.was_lookup));
			end
		end

	task automatic send(op_t op, bit typed, res_t want);
		res_t r;
		while (!quiet && $urandom_range(99) < 16) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = op.cmd;
		s_axis_tdata = {7'b0, op.cf, op.ci, op.rf, op.ri, op.val, op.addr};
		do
			@(posedge clk);
		while (!s_axis_tready);
		r = interpolate(op);
		pending_results.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (LAT + 8) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_e idx, logic [8:0] d);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == REG_TABLE_TYPE)
			cur_type = d[1:0];
		else
			cur_len = d;
	endtask

	function automatic op_t random_op();
		op_t op;
		int  span;
		op.cmd = ($urandom_range(99) < 65);
		op.addr = $urandom_range(255);
		case ($urandom_range(5))
			0: op.val = 33'h0_7fff_ffff;
			1: op.val = 33'h1_8000_0000;
			2: op.val = 33'h0_ffff_ffff;
			3: op.val = {1'($urandom_range(1)), 16'(0), 16'($urandom)};
			default: op.val = {1'($urandom_range(1)), 32'($urandom)};
		endcase
		span = (cur_len == 0) ? 15 : 256 / cur_len;
		op.ri = ($urandom_range(19) == 0) ? 8'd255 : 8'($urandom_range(span));
		op.ci = ($urandom_range(19) == 0) ? 8'd255 : 8'($urandom_range(cur_len > 255 ? 255 : cur_len));
		op.rf = ($urandom_range(9) == 0) ? 16'hffff : 16'($urandom);
		op.cf = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
		if (op.cmd && reads_unwritten(op)) begin
			op.cmd = 1'b0;
			for (int a = 0; a < DEPTH; a++)
				if (!written[a]) begin
					op.addr = a;
					if ($urandom_range(3) == 0)
						break;
				end
		end
		return op;
	endfunction

	row_t directed [] = '{
		'{'{0, 8'd0,   33'h0_0000_7fff, 0, 0, 0, 0}, 1, '{33'd0, 1'b0}},
		'{'{0, 8'd1,   33'h1_ffff_8000, 0, 0, 0, 0}, 1, '{33'd0, 1'b0}},
		'{'{0, 8'd16,  33'h0_7fff_ffff, 0, 0, 0, 0}, 1, '{33'd0, 1'b0}},
		'{'{0, 8'd17,  33'h1_8000_0000, 0, 0, 0, 0}, 1, '{33'd0, 1'b0}},
		'{'{0, 8'd255, 33'h0_ffff_ffff, 0, 0, 0, 0}, 1, '{33'd0, 1'b0}},
		'{'{1, 8'd0, 33'd0, 8'd0, 16'h0000, 8'd0, 16'h0000}, 0, '{33'd0, 1'b0}},
		'{'{1, 8'd0, 33'd0, 8'd0, 16'hffff, 8'd0, 16'hffff}, 0, '{33'd0, 1'b0}},
		'{'{1, 8'd0, 33'd0, 8'd0, 16'h8000, 8'd0, 16'h0001}, 0, '{33'd0, 1'b0}},
		'{'{1, 8'd0, 33'd0, 8'd0, 16'h5555, 8'd0, 16'haaaa}, 0, '{33'd0, 1'b0}},
		'{'{1, 8'd0, 33'd0, 8'd255, 16'hffff, 8'd255, 16'hffff}, 1, '{33'd0, 1'b1}},
		'{'{0, 8'd0,   33'h1_5555_5555, 0, 0, 0, 0}, 1, '{33'd0, 1'b0}},
		'{'{1, 8'd0, 33'd0, 8'd0, 16'h1234, 8'd0, 16'hedcb}, 0, '{33'd0, 1'b0}}
	};

	initial begin
		logic [1:0] types [] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd2};
		logic [8:0] lens  [] = '{9'd16, 9'd16, 9'd1, 9'd256, 9'd1, 9'd0, 9'd256, 9'd511, 9'd7, 9'd3};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TABLE_TYPE;
		cfg_data = '0;
		cur_type = TT_S16;
		cur_len = 9'd16;
		mismatches = 0;
		quiet = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send(directed[i].op, directed[i].typed, directed[i].res);
		for (int k = 0; k < 130; k++)
			send(random_op(), 1'b0, '{33'd0, 1'b0});
		drain();

		foreach (types[p]) begin
			write_reg(REG_TABLE_TYPE, {7'b0, types[p]});
			write_reg(REG_ROW_LENGTH, lens[p]);
			quiet = (p == 3);
			for (int k = 0; k < 130; k++) begin
				send(random_op(), 1'b0, '{33'd0, 1'b0});
				if (k == 60 && p == 5)
					drain();
			end
			drain();
		end
		quiet = 1'b0;

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
design/cmbi_pkg.sv
design/cmbi_table.sv
design/cmbi_blend.sv
design/calibration_map_bilinear_interp.sv
dv/testbench.sv
